// ===== rtl/letter_substitution_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// letter_substitution_cipher_assert.svh
// Assertion macros shared by the cipher RTL; each expects clk and rst_n
// ----------------------------------------------------------------------------
`ifndef LETTER_SUBSTITUTION_CIPHER_ASSERT_SVH
`define LETTER_SUBSTITUTION_CIPHER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define LSC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define LSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants, types and mod-26 helpers for the substitution cipher
// ----------------------------------------------------------------------------
package lsc_pkg;

    // default key store depth
    localparam int KEY_MAX_DEF = 64;

    // alphabet size and an underestimating reciprocal (39/1024 < 1/26)
    localparam logic [5:0]  ALPHA    = 6'd26;
    localparam logic [15:0] RECIP26  = 16'd39;

    // letter bounds
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // cipher mode codes
    localparam logic [2:0] MODE_ATBASH   = 3'd0;
    localparam logic [2:0] MODE_CAESAR   = 3'd1;
    localparam logic [2:0] MODE_AFFINE   = 3'd2;
    localparam logic [2:0] MODE_VIGENERE = 3'd3;
    localparam logic [2:0] MODE_BEAUFORT = 3'd4;
    localparam logic [2:0] MODE_AUTOKEY  = 3'd5;

    // request codes
    localparam logic [1:0] REQ_ENCIPHER  = 2'd0;
    localparam logic [1:0] REQ_KEY_WRITE = 2'd1;
    localparam logic [1:0] REQ_RESTART   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_CIPHER_MODE  = 3'd0;
    localparam logic [2:0] REG_CAESAR_SHIFT = 3'd1;
    localparam logic [2:0] REG_AFFINE_MUL   = 3'd2;
    localparam logic [2:0] REG_AFFINE_ADD   = 3'd3;
    localparam logic [2:0] REG_KEY_LENGTH   = 3'd4;

    // register reset values
    localparam logic [2:0] RST_CIPHER_MODE  = MODE_ATBASH;
    localparam logic [4:0] RST_CAESAR_SHIFT = 5'd3;
    localparam logic [4:0] RST_AFFINE_MUL   = 5'd1;
    localparam logic [4:0] RST_AFFINE_ADD   = 5'd0;
    localparam logic [6:0] RST_KEY_LENGTH   = 7'd1;

    // configuration register contents
    typedef struct packed {
        logic [2:0] cipher_mode;
        logic [4:0] caesar_shift;
        logic [4:0] affine_mul;
        logic [4:0] affine_add;
        logic [6:0] key_length;
    } cfg_t;

    // request seen by the key control at acceptance
    typedef struct packed {
        logic       accept;
        logic [1:0] req_type;
        logic       letter;
        logic [4:0] x;
        logic [5:0] key_slot;
        logic [4:0] key_shift;
    } key_req_t;

    // first pipeline stage contents
    typedef struct packed {
        logic [7:0] ch;
        logic       letter;
        logic       lower;
        logic [4:0] x;
        logic [9:0] aff_sum;
    } s1_t;

    // reduce a value below 52 to 0..25
    function automatic logic [4:0] mod26_small(input logic [5:0] v);
        logic [5:0] r;
        r = (v >= ALPHA) ? (v - ALPHA) : v;
        return r[4:0];
    endfunction

    // reduce a value below 1024 to 0..25: estimated quotient, then one correction
    function automatic logic [4:0] mod26_wide(input logic [9:0] v);
        logic [15:0] prod;
        logic [5:0]  q;
        logic [9:0]  r;
        prod = 16'(v) * RECIP26;
        q    = prod[15:10];
        r    = v - 10'(q) * 10'(ALPHA);
        return mod26_small(r[5:0]);
    endfunction

endpackage

// ===== rtl/lsc_ram.sv =====
// ----------------------------------------------------------------------------
// lsc_ram
// Simple dual-port RAM, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
module lsc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = lsc_pkg::KEY_MAX_DEF
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lsc_cfg.sv =====
// ----------------------------------------------------------------------------
// lsc_cfg
// APB register file holding the cipher configuration
// ----------------------------------------------------------------------------
module lsc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output lsc_pkg::cfg_t       cfg
);

    lsc_pkg::cfg_t cfg_reg;
    lsc_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                lsc_pkg::REG_CIPHER_MODE:  cfg_next.cipher_mode  = pwdata[2:0];
                lsc_pkg::REG_CAESAR_SHIFT: cfg_next.caesar_shift = pwdata[4:0];
                lsc_pkg::REG_AFFINE_MUL:   cfg_next.affine_mul   = pwdata[4:0];
                lsc_pkg::REG_AFFINE_ADD:   cfg_next.affine_add   = pwdata[4:0];
                lsc_pkg::REG_KEY_LENGTH:   cfg_next.key_length   = pwdata[6:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cipher_mode  <= lsc_pkg::RST_CIPHER_MODE;
            cfg_reg.caesar_shift <= lsc_pkg::RST_CAESAR_SHIFT;
            cfg_reg.affine_mul   <= lsc_pkg::RST_AFFINE_MUL;
            cfg_reg.affine_add   <= lsc_pkg::RST_AFFINE_ADD;
            cfg_reg.key_length   <= lsc_pkg::RST_KEY_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            lsc_pkg::REG_CIPHER_MODE:  prdata = 32'(cfg_reg.cipher_mode);
            lsc_pkg::REG_CAESAR_SHIFT: prdata = 32'(cfg_reg.caesar_shift);
            lsc_pkg::REG_AFFINE_MUL:   prdata = 32'(cfg_reg.affine_mul);
            lsc_pkg::REG_AFFINE_ADD:   prdata = 32'(cfg_reg.affine_add);
            lsc_pkg::REG_KEY_LENGTH:   prdata = 32'(cfg_reg.key_length);
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lsc_keyctl.sv =====
// ----------------------------------------------------------------------------
// lsc_keyctl
// Key position counter and key store; issues the key read for each letter
// ----------------------------------------------------------------------------
`include "letter_substitution_cipher_assert.svh"

module lsc_keyctl #(
    parameter int KEY_MAX = lsc_pkg::KEY_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lsc_pkg::cfg_t       cfg,
    input  lsc_pkg::key_req_t   req,
    output logic [4:0]          key
);

    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LW = $clog2(KEY_MAX + 1);
    localparam int CW = (LW > 7) ? LW : 7;
    localparam int SW = (LW > 6) ? LW : 6;

    logic [KW-1:0] key_position_reg;
    logic [KW-1:0] key_position_next;
    logic [LW-1:0] len_eff;
    logic [KW-1:0] pos_use;
    logic [LW-1:0] pos_inc;
    logic [KW-1:0] pos_wrap;
    logic          keyed;
    logic          use_key;
    logic          autokey;
    logic          slot_ok;
    logic          key_wr;
    logic          ram_we;
    logic [KW-1:0] ram_waddr;
    logic [4:0]    ram_wdata;

    // effective key length, clamped to 1..KEY_MAX
    always_comb
    begin
        priority if (cfg.key_length == 7'd0)
        begin
            len_eff = LW'(1);
        end
        else if (CW'(cfg.key_length) > CW'(KEY_MAX))
        begin
            len_eff = LW'(KEY_MAX);
        end
        else
        begin
            len_eff = LW'(cfg.key_length);
        end
    end

    // position used by this letter and the one after it
    assign pos_use  = (LW'(key_position_reg) >= len_eff) ? '0 : key_position_reg;
    assign pos_inc  = LW'(pos_use) + LW'(1);
    assign pos_wrap = (pos_inc >= len_eff) ? '0 : KW'(pos_inc);

    assign keyed   = (cfg.cipher_mode == lsc_pkg::MODE_VIGENERE) ||
                     (cfg.cipher_mode == lsc_pkg::MODE_BEAUFORT) ||
                     (cfg.cipher_mode == lsc_pkg::MODE_AUTOKEY);
    assign autokey = (cfg.cipher_mode == lsc_pkg::MODE_AUTOKEY);
    assign use_key = req.accept && (req.req_type == lsc_pkg::REQ_ENCIPHER) &&
                     req.letter && keyed;
    assign slot_ok = SW'(req.key_slot) < SW'(KEY_MAX);
    assign key_wr  = req.accept && (req.req_type == lsc_pkg::REQ_KEY_WRITE) && slot_ok;

    // autokey overwrites the slot just read with the plaintext letter
    assign ram_we    = key_wr || (use_key && autokey);
    assign ram_waddr = use_key ? pos_use : KW'(req.key_slot);
    assign ram_wdata = use_key ? req.x : lsc_pkg::mod26_small(6'(req.key_shift));

    // position update
    always_comb
    begin
        priority if (req.accept && (req.req_type == lsc_pkg::REQ_RESTART))
        begin
            key_position_next = '0;
        end
        else if (use_key)
        begin
            key_position_next = pos_wrap;
        end
        else
        begin
            key_position_next = key_position_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_position_reg <= '0;
        end
        else
        begin
            key_position_reg <= key_position_next;
        end
    end

    // key store
    lsc_ram #(
        .WIDTH (5),
        .DEPTH (KEY_MAX)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (use_key),
        .raddr (pos_use),
        .rdata (key)
    );

    `LSC_ASSERT_ALWAYS(a_pos_in_store, LW'(key_position_reg) < LW'(KEY_MAX), "key position beyond store")
    `LSC_ASSERT_NEXT(a_restart_clears, req.accept && (req.req_type == lsc_pkg::REQ_RESTART), key_position_reg == '0, "restart did not rewind key")
    `LSC_ASSERT_NEXT(a_pos_idle_hold, !req.accept, $stable(key_position_reg), "key position moved without an item")

endmodule

// ===== rtl/lsc_calc.sv =====
// ----------------------------------------------------------------------------
// lsc_calc
// Letter substitution for one character: mod-26 arithmetic per cipher mode
// ----------------------------------------------------------------------------
module lsc_calc (
    input  lsc_pkg::cfg_t   cfg,
    input  lsc_pkg::s1_t    s1,
    input  logic [4:0]      key,
    output logic [7:0]      char_out
);

    logic [4:0] k;
    logic [4:0] shift;
    logic [4:0] y;
    logic [7:0] base;

    assign k     = lsc_pkg::mod26_small(6'(key));
    assign shift = lsc_pkg::mod26_small(6'(cfg.caesar_shift));

    // per-mode letter mapping
    always_comb
    begin
        unique case (cfg.cipher_mode)
            lsc_pkg::MODE_ATBASH:
                y = 5'(lsc_pkg::ALPHA - 6'd1 - 6'(s1.x));
            lsc_pkg::MODE_CAESAR:
                y = lsc_pkg::mod26_small(6'(s1.x) + 6'(shift));
            lsc_pkg::MODE_AFFINE:
                y = lsc_pkg::mod26_wide(s1.aff_sum);
            lsc_pkg::MODE_VIGENERE, lsc_pkg::MODE_AUTOKEY:
                y = lsc_pkg::mod26_small(6'(s1.x) + 6'(k));
            lsc_pkg::MODE_BEAUFORT:
                y = lsc_pkg::mod26_small(6'(k) + lsc_pkg::ALPHA - 6'(s1.x));
            default:
                y = s1.x;
        endcase
    end

    // restore case, pass non-letters
    assign base     = s1.lower ? lsc_pkg::CHAR_LOWER_A : lsc_pkg::CHAR_UPPER_A;
    assign char_out = s1.letter ? (base + 8'(y)) : s1.ch;

endmodule

// ===== rtl/letter_substitution_cipher.sv =====
// ----------------------------------------------------------------------------
// letter_substitution_cipher
// Classical substitution cipher on an ASCII byte stream, one character per item
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser selects encipher, key write or restart,
//   tdata carries the character, key slot and key shift. m_axis carries one
//   enciphered character for every encipher item; key writes and restarts
//   produce nothing. Configuration registers sit on the APB port and must be
//   written only while the stream is idle; the block itself does not enforce it.
//   An item passes through the input stage, loaded when the item is accepted, and
//   then the output register, which loads from it once the output can advance.
//   Throughput: one item per cycle unless m_axis stalls; the key store reads a letter's
//   slot and writes the autokey letter back at the same edge (old data is read), and
//   a write from one item is seen by the read of the next, so no bubbles are needed.
//   Reset clears the pipeline and the key position and sets the registers to their
//   reset values; the key store contents are undefined until loaded by key writes.
//   When m_axis_tready is low a full output register holds, the input stage
//   still fills, and s_axis_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "letter_substitution_cipher_assert.svh"

module letter_substitution_cipher #(
    parameter int KEY_MAX = lsc_pkg::KEY_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_in[7:0], key_slot[13:8], key_shift[18:14]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // char_out[7:0]
);

    lsc_pkg::cfg_t     cfg;
    lsc_pkg::key_req_t key_req;
    lsc_pkg::s1_t      s1_reg;
    lsc_pkg::s1_t      s1_next;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic [7:0] calc_char;
    logic [4:0] key;
    logic       s1_adv;
    logic       accept;
    logic       enc_accept;
    logic       s1_stall;
    logic       s1_move;

    logic [1:0] req_type;
    logic [7:0] char_in;
    logic [5:0] key_slot;
    logic [4:0] key_shift;
    logic       is_upper;
    logic       is_lower;
    logic [4:0] aff_mul;
    logic [4:0] aff_add;

    assign req_type  = s_axis_tuser;
    assign char_in   = s_axis_tdata[7:0];
    assign key_slot  = s_axis_tdata[13:8];
    assign key_shift = s_axis_tdata[18:14];

    // handshake
    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // stage movement terms
    assign enc_accept = accept && (req_type == lsc_pkg::REQ_ENCIPHER);
    assign s1_stall   = s1_valid_reg && !s1_adv;
    assign s1_move    = s1_valid_reg && s1_adv;

    // configuration registers
    lsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // letter classification and affine product at the input
    assign is_upper = (char_in >= lsc_pkg::CHAR_UPPER_A) && (char_in <= lsc_pkg::CHAR_UPPER_Z);
    assign is_lower = (char_in >= lsc_pkg::CHAR_LOWER_A) && (char_in <= lsc_pkg::CHAR_LOWER_Z);
    assign aff_mul  = lsc_pkg::mod26_small(6'(cfg.affine_mul));
    assign aff_add  = lsc_pkg::mod26_small(6'(cfg.affine_add));

    always_comb
    begin
        s1_next.ch      = char_in;
        s1_next.letter  = is_upper || is_lower;
        s1_next.lower   = is_lower;
        s1_next.x       = 5'(char_in - (is_lower ? lsc_pkg::CHAR_LOWER_A
                                                 : lsc_pkg::CHAR_UPPER_A));
        s1_next.aff_sum = 10'(aff_mul) * 10'(s1_next.x) + 10'(aff_add);
    end

    // key position and key store
    always_comb
    begin
        key_req.accept    = accept;
        key_req.req_type  = req_type;
        key_req.letter    = s1_next.letter;
        key_req.x         = s1_next.x;
        key_req.key_slot  = key_slot;
        key_req.key_shift = key_shift;
    end

    lsc_keyctl #(
        .KEY_MAX (KEY_MAX)
    ) u_keyctl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (key_req),
        .key   (key)
    );

    // substitution on the stage-one item
    lsc_calc u_calc (
        .cfg      (cfg),
        .s1       (s1_reg),
        .key      (key),
        .char_out (calc_char)
    );

    // pipeline valid flags
    always_comb
    begin
        priority if (accept)
        begin
            s1_valid_next = (req_type == lsc_pkg::REQ_ENCIPHER);
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            out_data_reg <= calc_char;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `LSC_ASSERT_NEXT(a_enc_enters_s1, enc_accept, s1_valid_reg, "encipher item lost at input")
    `LSC_ASSERT_NEXT(a_s1_holds_on_stall, s1_stall, s1_valid_reg, "stalled item dropped")
    `LSC_ASSERT_NEXT(a_s1_moves_to_out, s1_move, out_valid_reg, "item did not reach output")

endmodule
